>>> design/icc_profile_chunk_assembler_core_assert.svh
// Assertion macros shared by the checker of the ICC chunk assembler.
`ifndef ICC_PROFILE_CHUNK_ASSEMBLER_CORE_ASSERT_SVH
`define ICC_PROFILE_CHUNK_ASSEMBLER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ICC_PCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ICC_PCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/icc_pca_pkg.sv
// Types and constants of the ICC profile chunk assembler.
package icc_pca_pkg;

  localparam logic [7:0]  APP2_CODE    = 8'hE2;
  localparam logic [15:0] HEADER_BYTES = 16'd14;
  localparam logic [63:0] SIG_HIGH     = 64'h4943435F50524F46;
  localparam logic [31:0] SIG_LOW      = 32'h494C4500;
  localparam logic [7:0]  MAX_SEQUENCE = 8'd255;
  localparam int          SLOTS        = 256;
  localparam int          QUEUE_DEPTH  = 2;
  localparam int          QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int          QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_COLLECT = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_PLACE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_ICC  = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_BAD_SEQ  = 3'd3,
    ST_DUP      = 3'd4,
    ST_NONE     = 3'd5,
    ST_MISSING  = 3'd6,
    ST_EMPTY    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PLACE,
    BK_WALK_RD,
    BK_WALK_ADD
  } back_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        icc;
    logic [7:0]  seq;
    logic [7:0]  cnt;
    logic [15:0] plen;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        icc;
    logic [23:0] dest;
    logic [15:0] plen;
    logic [23:0] total;
  } result_t;

endpackage

>>> design/icc_profile_chunk_assembler_core.sv
// Top level of the ICC profile chunk assembler for JPEG APP2 marker headers.
//
//   Channel   Handshake            Payload
//   in_       in_valid/in_ready    command, marker header fields
//   out_      out_valid/out_ready  status, is_icc, offset, lengths
//
// An item is registered in the two-entry queue and then handled by the back end from
// its idle state for clear, collect and any rejected command; place also passes through
// BK_PLACE for the registered table read. Finish walks the chunk table through BK_WALK_RD
// and BK_WALK_ADD for each chunk. Reset needs no clearing pass. While the back end
// stalls on a full output register, the queue accepts items until both entries fill.
module icc_profile_chunk_assembler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_marker_code,
  input  logic [15:0] in_data_length,
  input  logic [63:0] in_ident_high,
  input  logic [31:0] in_ident_low,
  input  logic [7:0]  in_seq_number,
  input  logic [7:0]  in_chunk_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_is_icc,
  output logic [23:0] out_dest_offset,
  output logic [15:0] out_payload_length,
  output logic [23:0] out_total_length
);

  logic                 q_valid;
  icc_pca_pkg::item_t   q_item;
  logic                 q_pop;
  icc_pca_pkg::result_t res;

  icc_pca_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_marker_code (in_marker_code),
    .in_data_length (in_data_length),
    .in_ident_high  (in_ident_high),
    .in_ident_low   (in_ident_low),
    .in_seq_number  (in_seq_number),
    .in_chunk_count (in_chunk_count),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  icc_pca_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_status         = res.status;
  assign out_is_icc         = res.icc;
  assign out_dest_offset    = res.dest;
  assign out_payload_length = res.plen;
  assign out_total_length   = res.total;

endmodule

>>> design/icc_pca_front.sv
// Front end: accepts items, classifies the marker header and queues it.
module icc_pca_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_marker_code,
  input  logic [15:0]         in_data_length,
  input  logic [63:0]         in_ident_high,
  input  logic [31:0]         in_ident_low,
  input  logic [7:0]          in_seq_number,
  input  logic [7:0]          in_chunk_count,
  output logic                q_valid,
  output icc_pca_pkg::item_t  q_item,
  input  logic                q_pop
);

  icc_pca_pkg::item_t                    fifo_r [icc_pca_pkg::QUEUE_DEPTH];
  logic [icc_pca_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [icc_pca_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [icc_pca_pkg::QCNT_W-1:0]        count_r, count_nxt;
  icc_pca_pkg::item_t                    new_item;
  logic                                  push;
  logic                                  pop;

  always_comb begin
    new_item.cmd  = icc_pca_pkg::cmd_t'(in_command);
    new_item.icc  = (in_marker_code == icc_pca_pkg::APP2_CODE) &&
                    (in_data_length >= icc_pca_pkg::HEADER_BYTES) &&
                    (in_ident_high == icc_pca_pkg::SIG_HIGH) &&
                    (in_ident_low == icc_pca_pkg::SIG_LOW);
    new_item.seq  = in_seq_number;
    new_item.cnt  = in_chunk_count;
    new_item.plen = in_data_length - icc_pca_pkg::HEADER_BYTES;
  end

  assign in_ready = (count_r != icc_pca_pkg::QCNT_W'(icc_pca_pkg::QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = fifo_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_pop;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

>>> design/icc_pca_back.sv
// Back end: executes queued commands against the chunk tables and drives results.
module icc_pca_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  icc_pca_pkg::item_t   q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output icc_pca_pkg::result_t out_res
);

  icc_pca_pkg::back_state_t     state_r, state_nxt;
  logic [icc_pca_pkg::SLOTS-1:0] present_r, present_nxt;
  logic [7:0]                   expected_r, expected_nxt;
  icc_pca_pkg::status_t         err_r, err_nxt;
  logic [23:0]                  total_r, total_nxt;
  logic                         fin_r, fin_nxt;
  logic [7:0]                   walk_r, walk_nxt;
  logic [23:0]                  sum_r, sum_nxt;
  logic                         out_valid_r, out_valid_nxt;
  icc_pca_pkg::result_t         res_r, res_nxt;

  logic [15:0]                  len_mem [icc_pca_pkg::SLOTS];
  logic [23:0]                  off_mem [icc_pca_pkg::SLOTS];
  logic [15:0]                  len_rd_r;
  logic [23:0]                  off_rd_r;
  logic                         len_we;
  logic                         off_we;
  logic [7:0]                   rd_addr;

  logic                         out_free;
  logic                         take;
  logic [7:0]                   col_exp;
  icc_pca_pkg::status_t         col_st;
  icc_pca_pkg::status_t         place_st;
  logic [23:0]                  sum_new;
  logic                         out_load;
  icc_pca_pkg::result_t         res_new;

  assign out_free  = !out_valid_r || out_ready;
  assign take      = (state_r == icc_pca_pkg::BK_IDLE) && q_valid && out_free;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign sum_new   = sum_r + {8'd0, len_rd_r};

  always_comb begin
    col_exp = (expected_r == 8'd0) ? q_item.cnt : expected_r;
    if (col_exp != q_item.cnt) begin
      col_st = icc_pca_pkg::ST_MISMATCH;
    end else if (q_item.seq == 8'd0 || q_item.seq > col_exp ||
                 q_item.seq > icc_pca_pkg::MAX_SEQUENCE) begin
      col_st = icc_pca_pkg::ST_BAD_SEQ;
    end else if (present_r[q_item.seq]) begin
      col_st = icc_pca_pkg::ST_DUP;
    end else begin
      col_st = icc_pca_pkg::ST_OK;
    end

    if (err_r != icc_pca_pkg::ST_OK) begin
      place_st = err_r;
    end else if (!fin_r) begin
      place_st = icc_pca_pkg::ST_NONE;
    end else if (!q_item.icc) begin
      place_st = icc_pca_pkg::ST_NOT_ICC;
    end else if (q_item.cnt != expected_r) begin
      place_st = icc_pca_pkg::ST_MISMATCH;
    end else if (q_item.seq == 8'd0 || q_item.seq > expected_r ||
                 q_item.seq > icc_pca_pkg::MAX_SEQUENCE) begin
      place_st = icc_pca_pkg::ST_BAD_SEQ;
    end else begin
      place_st = icc_pca_pkg::ST_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      icc_pca_pkg::BK_IDLE: begin
        if (take) begin
          if (q_item.cmd == icc_pca_pkg::CMD_FINISH && err_r == icc_pca_pkg::ST_OK &&
              expected_r != 8'd0) begin
            state_nxt = icc_pca_pkg::BK_WALK_RD;
          end else if (q_item.cmd == icc_pca_pkg::CMD_PLACE &&
                       place_st == icc_pca_pkg::ST_OK) begin
            state_nxt = icc_pca_pkg::BK_PLACE;
          end
        end
      end
      icc_pca_pkg::BK_PLACE: state_nxt = icc_pca_pkg::BK_IDLE;
      icc_pca_pkg::BK_WALK_RD: begin
        state_nxt = present_r[walk_r] ? icc_pca_pkg::BK_WALK_ADD : icc_pca_pkg::BK_IDLE;
      end
      icc_pca_pkg::BK_WALK_ADD: begin
        state_nxt = (walk_r == expected_r) ? icc_pca_pkg::BK_IDLE : icc_pca_pkg::BK_WALK_RD;
      end
      default: state_nxt = icc_pca_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    present_nxt   = present_r;
    expected_nxt  = expected_r;
    err_nxt       = err_r;
    total_nxt     = total_r;
    fin_nxt       = fin_r;
    walk_nxt      = walk_r;
    sum_nxt       = sum_r;
    q_pop         = take;
    len_we        = 1'b0;
    off_we        = 1'b0;
    rd_addr       = q_item.seq;
    out_load      = 1'b0;
    res_new       = '0;
    res_new.total = total_r;
    case (state_r)
      icc_pca_pkg::BK_IDLE: begin
        if (take) begin
          case (q_item.cmd)
            icc_pca_pkg::CMD_CLEAR: begin
              present_nxt   = '0;
              expected_nxt  = 8'd0;
              err_nxt       = icc_pca_pkg::ST_OK;
              total_nxt     = 24'd0;
              fin_nxt       = 1'b0;
              res_new.total = 24'd0;
              out_load      = 1'b1;
            end
            icc_pca_pkg::CMD_COLLECT: begin
              res_new.icc = q_item.icc;
              out_load    = 1'b1;
              if (err_r != icc_pca_pkg::ST_OK) begin
                res_new.status = err_r;
              end else if (!q_item.icc) begin
                res_new.status = icc_pca_pkg::ST_NOT_ICC;
              end else begin
                expected_nxt   = col_exp;
                res_new.status = col_st;
                if (col_st != icc_pca_pkg::ST_OK) begin
                  err_nxt = col_st;
                end else begin
                  present_nxt[q_item.seq] = 1'b1;
                  len_we                  = 1'b1;
                  fin_nxt                 = 1'b0;
                  res_new.plen            = q_item.plen;
                end
              end
            end
            icc_pca_pkg::CMD_FINISH: begin
              if (err_r != icc_pca_pkg::ST_OK) begin
                res_new.status = err_r;
                out_load       = 1'b1;
              end else if (expected_r == 8'd0) begin
                res_new.status = icc_pca_pkg::ST_NONE;
                err_nxt        = icc_pca_pkg::ST_NONE;
                out_load       = 1'b1;
              end else begin
                walk_nxt = 8'd1;
                sum_nxt  = 24'd0;
              end
            end
            icc_pca_pkg::CMD_PLACE: begin
              if (place_st != icc_pca_pkg::ST_OK) begin
                res_new.status = place_st;
                res_new.icc    = q_item.icc;
                out_load       = 1'b1;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      icc_pca_pkg::BK_PLACE: begin
        res_new.status = icc_pca_pkg::ST_OK;
        res_new.icc    = 1'b1;
        res_new.dest   = off_rd_r;
        res_new.plen   = len_rd_r;
        out_load       = 1'b1;
      end
      icc_pca_pkg::BK_WALK_RD: begin
        rd_addr = walk_r;
        if (!present_r[walk_r]) begin
          res_new.status = icc_pca_pkg::ST_MISSING;
          err_nxt        = icc_pca_pkg::ST_MISSING;
          out_load       = 1'b1;
        end
      end
      icc_pca_pkg::BK_WALK_ADD: begin
        rd_addr  = walk_r;
        off_we   = 1'b1;
        sum_nxt  = sum_new;
        walk_nxt = walk_r + 8'd1;
        if (walk_r == expected_r) begin
          out_load = 1'b1;
          if (sum_new == 24'd0) begin
            res_new.status = icc_pca_pkg::ST_EMPTY;
            err_nxt        = icc_pca_pkg::ST_EMPTY;
          end else begin
            total_nxt     = sum_new;
            fin_nxt       = 1'b1;
            res_new.total = sum_new;
          end
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    res_nxt       = out_load ? res_new : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icc_pca_pkg::BK_IDLE;
      present_r   <= '0;
      expected_r  <= 8'd0;
      err_r       <= icc_pca_pkg::ST_OK;
      total_r     <= 24'd0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      expected_r  <= expected_nxt;
      err_r       <= err_nxt;
      total_r     <= total_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[q_item.seq] <= q_item.plen;
    end
    len_rd_r <= len_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[walk_r] <= sum_r;
    end
    off_rd_r <= off_mem[rd_addr];
  end

endmodule

>>> design/icc_pca_checker.sv
// Port-level checker for the ICC chunk assembler, bound to the top level.
`include "icc_profile_chunk_assembler_core_assert.svh"

module icc_pca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_is_icc,
  input logic [23:0] out_dest_offset,
  input logic [15:0] out_payload_length
);

  logic status_ok;
  logic status_not_icc;

  assign status_ok      = (out_status == icc_pca_pkg::ST_OK);
  assign status_not_icc = (out_status == icc_pca_pkg::ST_NOT_ICC);

  `ICC_PCA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_payload_length))
  `ICC_PCA_ASSERT_IMP(a_offset_ok, clk, rst_n, out_valid && out_dest_offset != 24'd0, out_is_icc && status_ok)
  `ICC_PCA_ASSERT_IMP(a_length_ok, clk, rst_n, out_valid && out_payload_length != 16'd0, out_is_icc && status_ok)
  `ICC_PCA_ASSERT_IMP(a_not_icc, clk, rst_n, out_valid && status_not_icc, !out_is_icc)

endmodule

bind icc_profile_chunk_assembler_core icc_pca_checker u_icc_pca_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_is_icc         (out_is_icc),
  .out_dest_offset    (out_dest_offset),
  .out_payload_length (out_payload_length)
);
